// ===== rtl/modbus_rtu_register_poller_core_assert.svh =====
// Assertion macros shared by the checker of the Modbus RTU register poller.
// Needs nothing else; take it by include.
`ifndef MODBUS_RTU_REGISTER_POLLER_CORE_ASSERT_SVH
`define MODBUS_RTU_REGISTER_POLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("poller check failed");

// Next-cycle implication, disabled while reset is low.
`define MRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("poller check failed");

`endif

// ===== rtl/mrp_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte step of the register poller.
// No dependencies.
`timescale 1ns / 1ps

package mrp_pkg;

    localparam int MAX_REPLY_BYTES = 32;
    localparam int REQUEST_BYTES   = 8;
    localparam int REQ_BODY        = REQUEST_BYTES - 2;
    localparam int REQ_IDX_W       = $clog2(REQUEST_BYTES);
    localparam int IDX_W           = $clog2(MAX_REPLY_BYTES + 1);
    localparam int LEN_W           = (IDX_W > 6) ? IDX_W : 6;
    localparam int LEN_X           = LEN_W + 1;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] MS_MAX   = 16'hFFFF;

    localparam logic [7:0]  RST_SLAVE_ADDRESS  = 8'h01;
    localparam logic [7:0]  RST_READ_FUNCTION  = 8'h03;
    localparam logic [3:0]  RST_REGISTER_TOTAL = 4'd1;
    localparam logic [15:0] RST_POLL_PERIOD    = 16'd200;
    localparam logic [15:0] RST_SEND_TIMEOUT   = 16'd30;
    localparam logic [15:0] RST_REPLY_TIMEOUT  = 16'd100;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_SEL_W  = 3;

    typedef enum logic [CFG_SEL_W-1:0] {
        REG_POLLER_ENABLE    = 3'd0,
        REG_SLAVE_ADDRESS    = 3'd1,
        REG_READ_FUNCTION    = 3'd2,
        REG_FIRST_REGISTER   = 3'd3,
        REG_REGISTER_TOTAL   = 3'd4,
        REG_POLL_PERIOD_MS   = 3'd5,
        REG_SEND_TIMEOUT_MS  = 3'd6,
        REG_REPLY_TIMEOUT_MS = 3'd7
    } reg_sel_t;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_TX_DONE = 2'd1,
        OP_RX_BYTE = 2'd2,
        OP_LINK_ERR = 2'd3
    } opcode_t;

    localparam logic [1:0] PHASE_CODE_WAIT = 2'd0;
    localparam logic [1:0] PHASE_CODE_TX   = 2'd1;
    localparam logic [1:0] PHASE_CODE_RX   = 2'd2;

    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_TX   = 3'b010,
        PH_RX   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_data;
    } evt_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  tx_data;
        logic        run_last;
        logic        drive_enable;
        logic [1:0]  phase_now;
        logic [15:0] sensor_raw;
        logic        sensor_valid;
    } res_t;

    typedef struct packed {
        logic        poller_enable;
        logic [7:0]  slave_address;
        logic [7:0]  read_function;
        logic [15:0] first_register;
        logic [3:0]  register_total;
        logic [15:0] poll_period_ms;
        logic [15:0] send_timeout_ms;
        logic [15:0] reply_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic        drive_enable;
        logic [1:0]  phase_now;
        logic [15:0] sensor_raw;
        logic        sensor_valid;
    } status_t;

    typedef struct packed {
        logic                       load;
        logic                       is_req;
        logic [REQ_BODY-1:0][7:0]   body;
        status_t                    status;
    } job_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        unique case (ph)
            PH_TX:   code = PHASE_CODE_TX;
            PH_RX:   code = PHASE_CODE_RX;
            default: code = PHASE_CODE_WAIT;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/mrp_cfg.sv =====
// APB-style configuration registers of the register poller.
// Depends on mrp_pkg.
`timescale 1ns / 1ps

module mrp_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mrp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output mrp_pkg::cfg_t                   cfg
);

    mrp_pkg::cfg_t    cfg_reg;
    mrp_pkg::reg_sel_t sel;
    logic             wr_en;

    assign sel    = mrp_pkg::reg_sel_t'(paddr[mrp_pkg::CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poller_enable    <= 1'b1;
            cfg_reg.slave_address    <= mrp_pkg::RST_SLAVE_ADDRESS;
            cfg_reg.read_function    <= mrp_pkg::RST_READ_FUNCTION;
            cfg_reg.first_register   <= '0;
            cfg_reg.register_total   <= mrp_pkg::RST_REGISTER_TOTAL;
            cfg_reg.poll_period_ms   <= mrp_pkg::RST_POLL_PERIOD;
            cfg_reg.send_timeout_ms  <= mrp_pkg::RST_SEND_TIMEOUT;
            cfg_reg.reply_timeout_ms <= mrp_pkg::RST_REPLY_TIMEOUT;
        end
        else if (wr_en)
        begin
            unique case (sel)
                mrp_pkg::REG_POLLER_ENABLE:    cfg_reg.poller_enable    <= pwdata[0];
                mrp_pkg::REG_SLAVE_ADDRESS:    cfg_reg.slave_address    <= pwdata[7:0];
                mrp_pkg::REG_READ_FUNCTION:    cfg_reg.read_function    <= pwdata[7:0];
                mrp_pkg::REG_FIRST_REGISTER:   cfg_reg.first_register   <= pwdata[15:0];
                mrp_pkg::REG_REGISTER_TOTAL:   cfg_reg.register_total   <= pwdata[3:0];
                mrp_pkg::REG_POLL_PERIOD_MS:   cfg_reg.poll_period_ms   <= pwdata[15:0];
                mrp_pkg::REG_SEND_TIMEOUT_MS:  cfg_reg.send_timeout_ms  <= pwdata[15:0];
                mrp_pkg::REG_REPLY_TIMEOUT_MS: cfg_reg.reply_timeout_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            mrp_pkg::REG_POLLER_ENABLE:    prdata = {31'd0, cfg_reg.poller_enable};
            mrp_pkg::REG_SLAVE_ADDRESS:    prdata = {24'd0, cfg_reg.slave_address};
            mrp_pkg::REG_READ_FUNCTION:    prdata = {24'd0, cfg_reg.read_function};
            mrp_pkg::REG_FIRST_REGISTER:   prdata = {16'd0, cfg_reg.first_register};
            mrp_pkg::REG_REGISTER_TOTAL:   prdata = {28'd0, cfg_reg.register_total};
            mrp_pkg::REG_POLL_PERIOD_MS:   prdata = {16'd0, cfg_reg.poll_period_ms};
            mrp_pkg::REG_SEND_TIMEOUT_MS:  prdata = {16'd0, cfg_reg.send_timeout_ms};
            mrp_pkg::REG_REPLY_TIMEOUT_MS: prdata = {16'd0, cfg_reg.reply_timeout_ms};
            default:                       prdata = '0;
        endcase
    end

endmodule

// ===== rtl/mrp_engine.sv =====
// Poller state machine: timers, reply checking and request start.
// Depends on mrp_pkg. Hands one job per accepted event to mrp_out.
`timescale 1ns / 1ps

module mrp_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  mrp_pkg::cfg_t   cfg,
    input  logic            accept,
    input  mrp_pkg::evt_t   evt,
    output mrp_pkg::job_t   job
);

    mrp_pkg::phase_t                 phase_reg, phase_next;
    logic [15:0]                     ms_since_poll_reg, ms_since_poll_next;
    logic [15:0]                     ms_in_phase_reg, ms_in_phase_next;
    logic [mrp_pkg::IDX_W-1:0]       reply_index_reg, reply_index_next;
    logic [15:0]                     running_crc_reg, running_crc_next;
    logic                            header_good_reg, header_good_next;
    logic [7:0]                      reply_crc_low_reg, reply_crc_low_next;
    logic [15:0]                     captured_raw_reg, captured_raw_next;
    logic [15:0]                     held_raw_reg, held_raw_next;
    logic                            held_valid_reg, held_valid_next;
    mrp_pkg::job_t                   job_next;

    logic [mrp_pkg::LEN_W-1:0]       len;
    logic                            len_ok;
    logic [mrp_pkg::LEN_X-1:0]       idx_p2;
    logic [mrp_pkg::LEN_X-1:0]       len_x;
    logic [15:0]                     msp_inc;
    logic [15:0]                     mip_inc;
    logic [15:0]                     limit;
    logic                            start;

    assign len    = mrp_pkg::LEN_W'(5) + mrp_pkg::LEN_W'({cfg.register_total, 1'b0});
    assign len_ok = (len >= mrp_pkg::LEN_W'(7))
                 && (len <= mrp_pkg::LEN_W'(mrp_pkg::MAX_REPLY_BYTES));
    assign idx_p2 = mrp_pkg::LEN_X'(reply_index_reg) + mrp_pkg::LEN_X'(2);
    assign len_x  = mrp_pkg::LEN_X'(len);
    assign msp_inc = (ms_since_poll_reg < mrp_pkg::MS_MAX) ? ms_since_poll_reg + 16'd1
                                                           : ms_since_poll_reg;
    assign mip_inc = (ms_in_phase_reg < mrp_pkg::MS_MAX) ? ms_in_phase_reg + 16'd1
                                                         : ms_in_phase_reg;
    assign limit   = (phase_reg == mrp_pkg::PH_TX) ? cfg.send_timeout_ms
                                                   : cfg.reply_timeout_ms;

    always_comb
    begin
        phase_next         = phase_reg;
        ms_since_poll_next = ms_since_poll_reg;
        ms_in_phase_next   = ms_in_phase_reg;
        reply_index_next   = reply_index_reg;
        running_crc_next   = running_crc_reg;
        header_good_next   = header_good_reg;
        reply_crc_low_next = reply_crc_low_reg;
        captured_raw_next  = captured_raw_reg;
        held_raw_next      = held_raw_reg;
        held_valid_next    = held_valid_reg;
        start              = 1'b0;

        if (cfg.poller_enable)
        begin
            unique case (mrp_pkg::opcode_t'(evt.opcode))
                mrp_pkg::OP_TICK:
                begin
                    ms_since_poll_next = msp_inc;
                    if (!len_ok)
                    begin
                        held_valid_next = 1'b0;
                        phase_next      = mrp_pkg::PH_WAIT;
                    end
                    else if (phase_reg == mrp_pkg::PH_WAIT)
                    begin
                        if (msp_inc >= cfg.poll_period_ms)
                        begin
                            start              = 1'b1;
                            ms_since_poll_next = '0;
                            ms_in_phase_next   = '0;
                            phase_next         = mrp_pkg::PH_TX;
                        end
                    end
                    else
                    begin
                        ms_in_phase_next = mip_inc;
                        if (mip_inc >= limit)
                        begin
                            phase_next         = mrp_pkg::PH_WAIT;
                            ms_since_poll_next = '0;
                            held_valid_next    = 1'b0;
                        end
                    end
                end
                mrp_pkg::OP_TX_DONE:
                begin
                    if (phase_reg == mrp_pkg::PH_TX)
                    begin
                        phase_next       = mrp_pkg::PH_RX;
                        ms_in_phase_next = '0;
                        reply_index_next = '0;
                        running_crc_next = mrp_pkg::CRC_INIT;
                        header_good_next = 1'b1;
                    end
                end
                mrp_pkg::OP_RX_BYTE:
                begin
                    if (phase_reg == mrp_pkg::PH_RX
                        && mrp_pkg::LEN_X'(reply_index_reg) < len_x)
                    begin
                        if (idx_p2 < len_x)
                        begin
                            running_crc_next = mrp_pkg::crc_byte(running_crc_reg, evt.rx_data);
                            if (reply_index_reg == mrp_pkg::IDX_W'(0)
                                && evt.rx_data != cfg.slave_address)
                                header_good_next = 1'b0;
                            if (reply_index_reg == mrp_pkg::IDX_W'(1)
                                && evt.rx_data != cfg.read_function)
                                header_good_next = 1'b0;
                            if (reply_index_reg == mrp_pkg::IDX_W'(2) && evt.rx_data < 8'd2)
                                header_good_next = 1'b0;
                            if (reply_index_reg == mrp_pkg::IDX_W'(3))
                                captured_raw_next = {evt.rx_data, 8'h00};
                            if (reply_index_reg == mrp_pkg::IDX_W'(4))
                                captured_raw_next = {captured_raw_reg[15:8], evt.rx_data};
                        end
                        else if (idx_p2 == len_x)
                        begin
                            reply_crc_low_next = evt.rx_data;
                        end
                        else
                        begin
                            // final CRC byte: commit or drop the captured value
                            if (header_good_reg
                                && {evt.rx_data, reply_crc_low_reg} == running_crc_reg)
                            begin
                                held_raw_next   = captured_raw_reg;
                                held_valid_next = 1'b1;
                            end
                            else
                            begin
                                held_valid_next = 1'b0;
                            end
                            phase_next = mrp_pkg::PH_WAIT;
                        end
                        if (reply_index_reg < mrp_pkg::IDX_W'(mrp_pkg::MAX_REPLY_BYTES))
                            reply_index_next = reply_index_reg + mrp_pkg::IDX_W'(1);
                    end
                end
                default:
                begin
                    phase_next         = mrp_pkg::PH_WAIT;
                    ms_since_poll_next = '0;
                    held_valid_next    = 1'b0;
                end
            endcase
        end

        job_next.load                = accept;
        job_next.is_req              = start;
        job_next.body[0]             = cfg.slave_address;
        job_next.body[1]             = cfg.read_function;
        job_next.body[2]             = cfg.first_register[15:8];
        job_next.body[3]             = cfg.first_register[7:0];
        job_next.body[4]             = 8'h00;
        job_next.body[5]             = {4'h0, cfg.register_total};
        job_next.status.drive_enable = (phase_next == mrp_pkg::PH_TX);
        job_next.status.phase_now    = mrp_pkg::phase_code(phase_next);
        job_next.status.sensor_raw   = held_raw_next;
        job_next.status.sensor_valid = held_valid_next;
    end

    assign job = job_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= mrp_pkg::PH_WAIT;
            ms_since_poll_reg <= '0;
            ms_in_phase_reg   <= '0;
            reply_index_reg   <= '0;
            running_crc_reg   <= mrp_pkg::CRC_INIT;
            header_good_reg   <= 1'b1;
            reply_crc_low_reg <= '0;
            captured_raw_reg  <= '0;
            held_raw_reg      <= '0;
            held_valid_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            ms_since_poll_reg <= ms_since_poll_next;
            ms_in_phase_reg   <= ms_in_phase_next;
            reply_index_reg   <= reply_index_next;
            running_crc_reg   <= running_crc_next;
            header_good_reg   <= header_good_next;
            reply_crc_low_reg <= reply_crc_low_next;
            captured_raw_reg  <= captured_raw_next;
            held_raw_reg      <= held_raw_next;
            held_valid_reg    <= held_valid_next;
        end
    end

endmodule

// ===== rtl/mrp_out.sv =====
// Result register: holds one status result or walks the eight request bytes,
// folding the request CRC one byte per cycle unless stalled. Depends on mrp_pkg.
`timescale 1ns / 1ps

module mrp_out (
    input  logic            clk,
    input  logic            rst_n,
    input  mrp_pkg::job_t   job,
    output logic            free,
    output logic            res_valid,
    input  logic            res_stall,
    output mrp_pkg::res_t   res
);

    logic                                   busy_reg, busy_next;
    logic                                   is_req_reg, is_req_next;
    logic [mrp_pkg::REQ_IDX_W-1:0]          idx_reg, idx_next;
    logic [mrp_pkg::REQ_BODY-1:0][7:0]      body_reg, body_next;
    logic [15:0]                            crc_reg, crc_next;
    mrp_pkg::status_t                       stat_reg, stat_next;
    logic                                   fire;
    logic                                   last_now;
    logic                                   in_body;
    logic [7:0]                             tx_byte;

    localparam logic [mrp_pkg::REQ_IDX_W-1:0] IDX_LAST =
        mrp_pkg::REQ_IDX_W'(mrp_pkg::REQUEST_BYTES - 1);
    localparam logic [mrp_pkg::REQ_IDX_W-1:0] IDX_CRC_LO =
        mrp_pkg::REQ_IDX_W'(mrp_pkg::REQ_BODY);

    assign fire     = busy_reg && !res_stall;
    assign last_now = !is_req_reg || (idx_reg == IDX_LAST);
    assign free     = !busy_reg || (fire && last_now);
    assign in_body  = idx_reg < IDX_CRC_LO;

    always_comb
    begin
        if (!is_req_reg)
            tx_byte = 8'h00;
        else if (in_body)
            tx_byte = body_reg[idx_reg];
        else if (idx_reg == IDX_CRC_LO)
            tx_byte = crc_reg[7:0];
        else
            tx_byte = crc_reg[15:8];
    end

    assign res_valid        = busy_reg;
    assign res.out_kind     = is_req_reg ? mrp_pkg::KIND_REQUEST : mrp_pkg::KIND_STATUS;
    assign res.tx_data      = tx_byte;
    assign res.run_last     = last_now;
    assign res.drive_enable = stat_reg.drive_enable;
    assign res.phase_now    = stat_reg.phase_now;
    assign res.sensor_raw   = stat_reg.sensor_raw;
    assign res.sensor_valid = stat_reg.sensor_valid;

    always_comb
    begin
        busy_next   = busy_reg;
        is_req_next = is_req_reg;
        idx_next    = idx_reg;
        body_next   = body_reg;
        crc_next    = crc_reg;
        stat_next   = stat_reg;
        if (job.load)
        begin
            busy_next   = 1'b1;
            is_req_next = job.is_req;
            idx_next    = '0;
            body_next   = job.body;
            crc_next    = mrp_pkg::CRC_INIT;
            stat_next   = job.status;
        end
        else if (fire)
        begin
            if (last_now)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + mrp_pkg::REQ_IDX_W'(1);
                // fold the byte just sent into the request CRC
                if (in_body)
                    crc_next = mrp_pkg::crc_byte(crc_reg, body_reg[idx_reg]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            is_req_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            is_req_reg <= is_req_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        body_reg <= body_next;
        crc_reg  <= crc_next;
        stat_reg <= stat_next;
    end

endmodule

// ===== rtl/modbus_rtu_register_poller_core.sv =====
// Modbus RTU register poller: one event in, one status result or eight request bytes out.
// Latency: results of an event appear in the cycle after it is accepted.
// Throughput: one event per cycle while results are taken; a poll start occupies the
// result register for eight request bytes, one per unstalled cycle; events stall meanwhile.
// Reset: registers to defaults, waiting phase, timers zero, sensor value and valid cleared.
// Depends on mrp_pkg, mrp_cfg, mrp_engine, mrp_out.
`timescale 1ns / 1ps

module modbus_rtu_register_poller_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            evt_valid,
    output logic                            evt_stall,
    input  mrp_pkg::evt_t                   evt,
    output logic                            res_valid,
    input  logic                            res_stall,
    output mrp_pkg::res_t                   res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mrp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    mrp_pkg::cfg_t cfg;
    mrp_pkg::job_t job;
    logic          free;
    logic          accept;

    assign evt_stall = !free;
    assign accept    = evt_valid && free;

    mrp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mrp_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .evt    (evt),
        .job    (job)
    );

    mrp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .free      (free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// ===== rtl/mrp_checker.sv =====
// Port-level checks for the register poller, bound to the top level.
// Depends on mrp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "modbus_rtu_register_poller_core_assert.svh"

module mrp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          evt_valid,
    input logic          evt_stall,
    input logic          res_valid,
    input logic          res_stall,
    input mrp_pkg::res_t res
);

    `MRP_ASSERT_NOW(a_drive_matches_phase, clk, rst_n, res_valid, res.drive_enable == (res.phase_now == mrp_pkg::PHASE_CODE_TX))
    `MRP_ASSERT_NOW(a_status_single, clk, rst_n, res_valid && res.out_kind == mrp_pkg::KIND_STATUS, res.run_last && res.tx_data == 8'h00)
    `MRP_ASSERT_NOW(a_burst_blocks_events, clk, rst_n, res_valid && res.out_kind == mrp_pkg::KIND_REQUEST && !res.run_last, evt_stall)
    `MRP_ASSERT_NEXT(a_burst_continues, clk, rst_n, res_valid && !res_stall && res.out_kind == mrp_pkg::KIND_REQUEST && !res.run_last, res_valid && res.out_kind == mrp_pkg::KIND_REQUEST)
    `MRP_ASSERT_NEXT(a_event_gives_result, clk, rst_n, evt_valid && !evt_stall, res_valid)

endmodule

bind modbus_rtu_register_poller_core mrp_checker u_mrp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

// ===== verif/modbus_rtu_register_poller_core_tb.sv =====
// Self-checking testbench for the Modbus RTU register poller core: poll, reply and
// error events go in over valid/stall, and every result is scored against a predictor.
// Depends on mrp_pkg and modbus_rtu_register_poller_core.
`timescale 1ns / 1ps

module modbus_rtu_register_poller_core_tb;

    import mrp_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    // Predicts the poller from the accepted requests and scores its results.
    class poll_scoreboard;
        logic        enable;
        logic [7:0]  slave_addr;
        logic [7:0]  read_func;
        logic [15:0] first_reg;
        logic [3:0]  reg_total;
        logic [15:0] period_ms;
        logic [15:0] send_limit;
        logic [15:0] reply_limit;

        logic [1:0]  phase;
        logic [15:0] since_poll;
        logic [15:0] in_phase;
        int          reply_idx;
        logic [15:0] reply_crc;
        logic        header_ok;
        logic [7:0]  crc_low;
        logic [15:0] captured;
        logic [15:0] held_raw;
        logic        held_valid;

        res_t        pending[$];
        int          errors;

        function new();
            enable      = 1'b1;
            slave_addr  = RST_SLAVE_ADDRESS;
            read_func   = RST_READ_FUNCTION;
            first_reg   = 16'h0000;
            reg_total   = RST_REGISTER_TOTAL;
            period_ms   = RST_POLL_PERIOD;
            send_limit  = RST_SEND_TIMEOUT;
            reply_limit = RST_REPLY_TIMEOUT;
            phase       = PHASE_CODE_WAIT;
            since_poll  = 16'h0000;
            in_phase    = 16'h0000;
            reply_idx   = 0;
            reply_crc   = 16'hFFFF;
            header_ok   = 1'b1;
            crc_low     = 8'h00;
            captured    = 16'h0000;
            held_raw    = 16'h0000;
            held_valid  = 1'b0;
            errors      = 0;
        endfunction

        // CRC-16/MODBUS, reflected, one data bit at a time
        static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            logic        fb;
            c = crc;
            for (int i = 0; i < 8; i++)
            begin
                fb = c[0] ^ b[i];
                c = c >> 1;
                if (fb)
                    c = c ^ 16'hA001;
            end
            return c;
        endfunction

        function void set_register(reg_sel_t sel, logic [31:0] v);
            case (sel)
                REG_POLLER_ENABLE:    enable      = v[0];
                REG_SLAVE_ADDRESS:    slave_addr  = v[7:0];
                REG_READ_FUNCTION:    read_func   = v[7:0];
                REG_FIRST_REGISTER:   first_reg   = v[15:0];
                REG_REGISTER_TOTAL:   reg_total   = v[3:0];
                REG_POLL_PERIOD_MS:   period_ms   = v[15:0];
                REG_SEND_TIMEOUT_MS:  send_limit  = v[15:0];
                REG_REPLY_TIMEOUT_MS: reply_limit = v[15:0];
                default: ;
            endcase
        endfunction

        function void queue_result(logic kind, logic [7:0] data, logic last);
            res_t r;
            r.out_kind     = kind;
            r.tx_data      = data;
            r.run_last     = last;
            r.drive_enable = (phase == PHASE_CODE_TX);
            r.phase_now    = phase;
            r.sensor_raw   = held_raw;
            r.sensor_valid = held_valid;
            pending.push_back(r);
        endfunction

        function void recover();
            phase      = PHASE_CODE_WAIT;
            since_poll = 16'h0000;
            held_valid = 1'b0;
        endfunction

        function void note_event(evt_t e);
            int          len;
            bit          len_ok;
            logic [15:0] limit;
            logic [15:0] c;
            logic [7:0]  req[8];
            logic [7:0]  rx;
            int          i;
            len    = 5 + 2 * int'(reg_total);
            len_ok = (len >= 7) && (len <= MAX_REPLY_BYTES);
            rx     = e.rx_data;
            if (enable)
            begin
                case (opcode_t'(e.opcode))
                    OP_TICK:
                    begin
                        if (since_poll != 16'hFFFF)
                            since_poll++;
                        if (!len_ok)
                        begin
                            held_valid = 1'b0;
                            phase      = PHASE_CODE_WAIT;
                        end
                        else if (phase == PHASE_CODE_WAIT)
                        begin
                            if (since_poll >= period_ms)
                            begin
                                since_poll = 16'h0000;
                                in_phase   = 16'h0000;
                                phase      = PHASE_CODE_TX;
                                req[0] = slave_addr;
                                req[1] = read_func;
                                req[2] = first_reg[15:8];
                                req[3] = first_reg[7:0];
                                req[4] = 8'h00;
                                req[5] = {4'h0, reg_total};
                                c = 16'hFFFF;
                                for (i = 0; i < 6; i++)
                                    c = crc_step(c, req[i]);
                                req[6] = c[7:0];
                                req[7] = c[15:8];
                                for (i = 0; i < REQUEST_BYTES; i++)
                                    queue_result(KIND_REQUEST, req[i], i == REQUEST_BYTES - 1);
                                return;
                            end
                        end
                        else
                        begin
                            limit = (phase == PHASE_CODE_TX) ? send_limit : reply_limit;
                            if (in_phase != 16'hFFFF)
                                in_phase++;
                            if (in_phase >= limit)
                                recover();
                        end
                    end
                    OP_TX_DONE:
                    begin
                        if (phase == PHASE_CODE_TX)
                        begin
                            phase     = PHASE_CODE_RX;
                            in_phase  = 16'h0000;
                            reply_idx = 0;
                            reply_crc = 16'hFFFF;
                            header_ok = 1'b1;
                        end
                    end
                    OP_RX_BYTE:
                    begin
                        if (phase == PHASE_CODE_RX && reply_idx < len)
                        begin
                            i = reply_idx;
                            if (i + 2 < len)
                            begin
                                reply_crc = crc_step(reply_crc, rx);
                                if (i == 0 && rx != slave_addr)
                                    header_ok = 1'b0;
                                if (i == 1 && rx != read_func)
                                    header_ok = 1'b0;
                                if (i == 2 && rx < 8'd2)
                                    header_ok = 1'b0;
                                if (i == 3)
                                    captured = {rx, 8'h00};
                                if (i == 4)
                                    captured = {captured[15:8], rx};
                            end
                            else if (i + 2 == len)
                            begin
                                crc_low = rx;
                            end
                            else
                            begin
                                if (header_ok && {rx, crc_low} == reply_crc)
                                begin
                                    held_raw   = captured;
                                    held_valid = 1'b1;
                                end
                                else
                                begin
                                    held_valid = 1'b0;
                                end
                                phase = PHASE_CODE_WAIT;
                            end
                            if (reply_idx < MAX_REPLY_BYTES)
                                reply_idx++;
                        end
                    end
                    default: recover();
                endcase
            end
            queue_result(KIND_STATUS, 8'h00, 1'b1);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with nothing pending, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("out_kind", want.out_kind, got.out_kind);
            compare_field("tx_data", want.tx_data, got.tx_data);
            compare_field("run_last", want.run_last, got.run_last);
            compare_field("drive_enable", want.drive_enable, got.drive_enable);
            compare_field("phase_now", want.phase_now, got.phase_now);
            compare_field("sensor_raw", want.sensor_raw, got.sensor_raw);
            compare_field("sensor_valid", want.sensor_valid, got.sensor_valid);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   evt_valid = 1'b0;
    logic                   evt_stall;
    evt_t                   evt = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    res_t                   res;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    poll_scoreboard sb;
    int             send_idle_pct = 0;
    int             res_stall_pct = 0;
    int             quiet_cycles = 0;
    int             item_count = 0;
    logic [7:0]     reply_buf[$];

    modbus_rtu_register_poller_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(99) < res_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                sb.check_result(res);
            if ((evt_valid && !evt_stall) || (res_valid && !res_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_event(opcode_t op, logic [7:0] data);
        evt_t e;
        e.opcode  = op;
        e.rx_data = data;
        if ($urandom_range(99) < send_idle_pct)
        begin
            evt_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        evt_valid <= 1'b1;
        evt       <= e;
        do @(posedge clk); while (evt_stall);
        sb.note_event(e);
    endtask

    task automatic send_counted(opcode_t op, logic [7:0] data);
        send_event(op, data);
        item_count++;
    endtask

    task automatic send_noise();
        send_event(opcode_t'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    // Hold the request side until every predicted result has drained.
    task automatic wait_drain();
        evt_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(reg_sel_t sel, logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(sel, v);
    endtask

    task automatic make_reply(logic [7:0] addr, logic [7:0] func, logic [7:0] count,
                              int regs, logic [15:0] first_val);
        logic [15:0] c;
        int          len;
        len = 5 + 2 * regs;
        reply_buf.delete();
        reply_buf.push_back(addr);
        reply_buf.push_back(func);
        reply_buf.push_back(count);
        reply_buf.push_back(first_val[15:8]);
        reply_buf.push_back(first_val[7:0]);
        for (int i = 5; i < len - 2; i++)
            reply_buf.push_back(8'($urandom_range(255)));
        c = 16'hFFFF;
        foreach (reply_buf[i])
            c = poll_scoreboard::crc_step(c, reply_buf[i]);
        reply_buf.push_back(c[7:0]);
        reply_buf.push_back(c[15:8]);
    endtask

    // One poll: tick until the request goes out, turn the line, then feed a reply
    // that is mostly well formed and sometimes damaged.
    task automatic run_poll_cycle();
        int         n;
        int         r;
        int         pos;
        int         mid_tick;
        int         rewrite_at;
        logic [7:0] addr;
        logic [7:0] func;
        logic [7:0] count;
        if (sb.phase == PHASE_CODE_RX && $urandom_range(1) == 1)
            send_counted(OP_LINK_ERR, 8'($urandom_range(255)));
        n = 0;
        while (sb.phase != PHASE_CODE_TX && n < 8)
        begin
            send_counted(OP_TICK, 8'($urandom_range(255)));
            n++;
        end
        if (sb.phase != PHASE_CODE_TX)
            return;
        if ($urandom_range(9) == 0)
            send_counted(OP_TICK, 8'($urandom_range(255)));
        send_counted(OP_TX_DONE, 8'($urandom_range(255)));

        addr  = sb.slave_addr;
        func  = sb.read_func;
        count = 8'(2 * int'(sb.reg_total));
        r     = $urandom_range(99);
        if (r < 6)
            addr = addr ^ 8'($urandom_range(1, 255));
        else if (r < 12)
            func = func ^ 8'($urandom_range(1, 255));
        else if (r < 17)
            count = 8'($urandom_range(1));
        else if (r < 22)
            count = 8'($urandom_range(2, 255));
        make_reply(addr, func, count, int'(sb.reg_total), 16'($urandom_range(65535)));
        if (r >= 22 && r < 30)
        begin
            pos = $urandom_range(reply_buf.size() - 1);
            reply_buf[pos] = reply_buf[pos] ^ 8'(1 << $urandom_range(7));
        end
        else if (r >= 30 && r < 34)
        begin
            void'(reply_buf.pop_back());
        end

        mid_tick   = ($urandom_range(19) == 0) ? $urandom_range(reply_buf.size() - 1) : -1;
        rewrite_at = ($urandom_range(24) == 0) ? $urandom_range(1, reply_buf.size() - 1) : -1;
        foreach (reply_buf[i])
        begin
            if (i == mid_tick)
                send_counted(OP_TICK, 8'($urandom_range(255)));
            // change the register count while the reply is still coming in
            if (i == rewrite_at)
            begin
                wait_drain();
                write_reg(REG_REGISTER_TOTAL, $urandom_range(1, 13));
            end
            send_counted(OP_RX_BYTE, reply_buf[i]);
        end
        if ($urandom_range(11) == 0)
            send_counted(OP_RX_BYTE, 8'($urandom_range(255)));
    endtask

    task automatic load_settings(int k);
        logic        en;
        logic [7:0]  addr;
        logic [7:0]  func;
        logic [15:0] first;
        logic [3:0]  total;
        logic [15:0] period;
        logic [15:0] send_to;
        logic [15:0] reply_to;
        en       = 1'b1;
        addr     = 8'($urandom_range(255));
        func     = ($urandom_range(1) == 1) ? 8'h03 : 8'($urandom_range(255));
        first    = 16'($urandom_range(65535));
        total    = ($urandom_range(3) == 0) ? 4'($urandom_range(1, 13)) : 4'($urandom_range(1, 3));
        period   = 16'($urandom_range(5));
        send_to  = ($urandom_range(3) == 0) ? 16'($urandom_range(2))
                                            : 16'($urandom_range(3, 65535));
        reply_to = ($urandom_range(3) == 0) ? 16'($urandom_range(2))
                                            : 16'($urandom_range(3, 65535));
        case (k)
            0:
            begin
                addr     = 8'h00;
                func     = 8'h00;
                first    = 16'h0000;
                total    = 4'd1;
                period   = 16'd0;
                send_to  = 16'hFFFF;
                reply_to = 16'hFFFF;
            end
            1:
            begin
                addr     = 8'hFF;
                func     = 8'hFF;
                first    = 16'hFFFF;
                total    = 4'd13;
                period   = 16'd1;
                send_to  = 16'd0;
                reply_to = 16'd40;
            end
            2: en = 1'b0;
            3: total = 4'd0;
            4: total = 4'd15;
            default: ;
        endcase
        write_reg(REG_POLLER_ENABLE, {31'b0, en});
        write_reg(REG_SLAVE_ADDRESS, {24'b0, addr});
        write_reg(REG_READ_FUNCTION, {24'b0, func});
        write_reg(REG_FIRST_REGISTER, {16'b0, first});
        write_reg(REG_REGISTER_TOTAL, {28'b0, total});
        write_reg(REG_POLL_PERIOD_MS, {16'b0, period});
        write_reg(REG_SEND_TIMEOUT_MS, {16'b0, send_to});
        write_reg(REG_REPLY_TIMEOUT_MS, {16'b0, reply_to});
    endtask

    initial
    begin
        int budget;
        int hold_at;
        int len;
        bit held;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 34;
        res_stall_pct = 56;

        // short timers so every phase and both timeouts show up in a few events
        write_reg(REG_POLL_PERIOD_MS, 1);
        write_reg(REG_SEND_TIMEOUT_MS, 2);
        write_reg(REG_REPLY_TIMEOUT_MS, 1);

        send_event(OP_LINK_ERR, 8'h00);
        send_event(OP_TX_DONE, 8'hFF);
        send_event(OP_RX_BYTE, 8'hFF);
        send_event(OP_TICK, 8'h00);
        send_event(OP_RX_BYTE, 8'h00);
        send_event(OP_TICK, 8'hFF);
        send_event(OP_TX_DONE, 8'h00);
        make_reply(8'h01, 8'h03, 8'h02, 1, 16'hFF00);
        foreach (reply_buf[i])
            send_event(OP_RX_BYTE, reply_buf[i]);
        send_event(OP_RX_BYTE, 8'hA5);
        send_event(OP_TICK, 8'h00);
        send_event(OP_LINK_ERR, 8'hFF);
        send_event(OP_TICK, 8'h00);
        send_event(OP_TICK, 8'h00);
        send_event(OP_TICK, 8'h00);
        send_event(OP_TICK, 8'h00);
        send_event(OP_TX_DONE, 8'h00);
        send_event(OP_TICK, 8'h00);

        for (int k = 0; k < 9; k++)
        begin
            send_idle_pct = (k < 3) ? 34 : (k < 6) ? 56 : 0;
            res_stall_pct = (k < 3) ? 56 : (k < 6) ? 34 : 0;
            wait_drain();
            load_settings(k);
            len    = 5 + 2 * int'(sb.reg_total);
            budget = !sb.enable ? 0 : (len >= 7 && len <= MAX_REPLY_BYTES) ? 38 : 15;
            if (!sb.enable)
                repeat (12) send_noise();
            hold_at    = $urandom_range(5, 30);
            held       = 1'b0;
            item_count = 0;
            while (item_count < budget)
            begin
                if ($urandom_range(99) < 80)
                    run_poll_cycle();
                else
                    send_noise();
                if (!held && item_count >= hold_at)
                begin
                    wait_drain();
                    held = 1'b1;
                end
            end
        end

        // hold a bad length for a few ticks, then poll again once it is restored
        wait_drain();
        write_reg(REG_POLLER_ENABLE, 1);
        write_reg(REG_REGISTER_TOTAL, 0);
        write_reg(REG_POLL_PERIOD_MS, 2);
        repeat (6) send_event(OP_TICK, 8'($urandom_range(255)));
        wait_drain();
        write_reg(REG_REGISTER_TOTAL, 1);
        run_poll_cycle();

        evt_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
